// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_AT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  `ASSERT_AT(name, clk, rst_n, !(cond))
`else
`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

// ===== hdl/hcbp_pkg.sv =====
package hcbp_pkg;

  localparam int KindW      = 2;
  localparam int SymW       = 8;
  localparam int LenFieldW  = 5;
  localparam int CodeFieldW = 16;
  localparam int ByteW      = 8;
  localparam int TotalW     = 32;
  localparam int PendW      = 7;
  localparam int CntW       = 3;
  // pending bits plus the longest code
  localparam int CombW      = PendW + CodeFieldW;
  localparam int AlignW     = CombW + 1;
  localparam int SumW       = 5;

  localparam logic [KindW-1:0] KindLoad   = 2'd0;
  localparam logic [KindW-1:0] KindEncode = 2'd1;
  localparam logic [KindW-1:0] KindFlush  = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              byte_valid;
    logic              last;
    logic [TotalW-1:0] total_bits;
  } hcbp_result_t;

  typedef struct packed {
    logic [1:0]   count;
    hcbp_result_t first;
    hcbp_result_t second;
  } hcbp_push_t;

endpackage

// ===== hdl/huffman_code_table_bit_packer_top.sv =====
// Each accepted item is registered at the table read; the packer then writes its results into the queue.
// Throughput: one item per cycle while the four-entry output queue has two free slots; the
// output port moves one result per cycle, so an encode that completes two bytes gives two results.
// The code table is one synchronous RAM, read once per accepted item and written by each in-range load.
// Reset (rst_ni, asynchronous) clears the per-entry valid bits, the packer and the
// queue at once; no clearing pass runs, so items are accepted right after reset.
`include "assert_macros.svh"

module huffman_code_table_bit_packer_top #(
  parameter int MAX_CODE_LEN = 16,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [hcbp_pkg::KindW-1:0]      kind_i,
  input  logic [hcbp_pkg::SymW-1:0]       symbol_i,
  input  logic [hcbp_pkg::LenFieldW-1:0]  code_length_i,
  input  logic [hcbp_pkg::CodeFieldW-1:0] code_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hcbp_pkg::ByteW-1:0]      out_byte_o,
  output logic                            byte_valid_o,
  output logic                            last_o,
  output logic [hcbp_pkg::TotalW-1:0]     total_bits_o
);
  import hcbp_pkg::*;

  localparam int CapLen = (MAX_CODE_LEN < CodeFieldW) ? MAX_CODE_LEN : CodeFieldW;
  localparam int LenW   = $clog2(CapLen + 1);
  localparam int CodeW  = CapLen;
  localparam int EntryW = LenW + CodeW;
  localparam int IdxW   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // ---------------- stage 0: table access ----------------
  logic              in_fire, sym_ok, load_fire;
  logic [IdxW-1:0]   sym_idx;
  logic [LenW-1:0]   wr_len;
  logic [EntryW-1:0] wr_entry;

  logic [EntryW-1:0]       table_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] tbl_vld_q;
  logic [EntryW-1:0]       rd_data_q;
  logic                    rd_vld_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign sym_ok    = 32'(symbol_i) < SYMBOL_COUNT;
  assign sym_idx   = symbol_i[IdxW-1:0];
  assign load_fire = in_fire && (kind_i == KindLoad) && sym_ok;
  assign wr_len    = (int'(code_length_i) > CapLen) ? LenW'(CapLen) : LenW'(code_length_i);
  assign wr_entry  = {wr_len, code_bits_i[CodeW-1:0]};

  always_ff @(posedge clk_i) begin
    if (load_fire) table_mem[sym_idx] <= wr_entry;
    if (in_fire) begin
      rd_data_q <= table_mem[sym_idx];
      rd_vld_q  <= sym_ok && tbl_vld_q[sym_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
    end else if (load_fire) begin
      tbl_vld_q[sym_idx] <= 1'b1;
    end
  end

  // ---------------- stage 1: bit packer ----------------
  logic s1_valid_q, s1_valid_d;
  logic s1_flush_q;
  logic s1_fire, room;

  logic [PendW-1:0]  pend_bits_q, pend_bits_d;
  logic [CntW-1:0]   pend_cnt_q, pend_cnt_d;
  logic [TotalW-1:0] bit_total_q, bit_total_d;

  logic [LenW-1:0]       enc_len;
  logic [CodeFieldW-1:0] code_ext, code_masked;
  logic [CombW-1:0]      comb_val;
  logic [SumW-1:0]       bit_sum;
  logic [AlignW-1:0]     aligned;
  logic [1:0]            n_bytes;
  logic [TotalW:0]       total_sum;
  logic [TotalW-1:0]     total_new;
  logic [ByteW-1:0]      flush_byte;
  hcbp_push_t            push;
  hcbp_result_t          head;

  assign s1_fire    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_comb begin
    enc_len     = rd_vld_q ? rd_data_q[EntryW-1 -: LenW] : '0;
    code_ext    = CodeFieldW'(rd_data_q[CodeW-1:0]);
    code_masked = code_ext & ~({CodeFieldW{1'b1}} << enc_len);
    comb_val    = (CombW'(pend_bits_q) << enc_len) | CombW'(code_masked);
    bit_sum     = SumW'(pend_cnt_q) + SumW'(enc_len);
    // left-justify the valid bits so whole bytes sit at the top
    aligned     = AlignW'(comb_val) << (SumW'(AlignW) - bit_sum);
    n_bytes     = bit_sum[SumW-1 -: 2];
    total_sum   = {1'b0, bit_total_q} + (TotalW + 1)'(enc_len);
    total_new   = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
    flush_byte  = ByteW'(pend_bits_q) << (4'(ByteW) - 4'(pend_cnt_q));

    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    bit_total_d = bit_total_q;
    push        = '0;
    if (s1_fire) begin
      if (s1_flush_q) begin
        push.count             = 2'd1;
        push.first.out_byte    = flush_byte;
        push.first.byte_valid  = (pend_cnt_q != '0);
        push.first.last        = 1'b1;
        push.first.total_bits  = bit_total_q;
        pend_bits_d            = '0;
        pend_cnt_d             = '0;
        bit_total_d            = '0;
      end else begin
        push.count             = n_bytes;
        push.first.out_byte    = aligned[AlignW-1 -: ByteW];
        push.first.byte_valid  = 1'b1;
        push.first.last        = (n_bytes == 2'd1);
        push.first.total_bits  = total_new;
        push.second.out_byte   = aligned[AlignW-ByteW-1 -: ByteW];
        push.second.byte_valid = 1'b1;
        push.second.last       = 1'b1;
        push.second.total_bits = total_new;
        pend_bits_d = comb_val[PendW-1:0] & ~({PendW{1'b1}} << bit_sum[CntW-1:0]);
        pend_cnt_d  = bit_sum[CntW-1:0];
        bit_total_d = total_new;
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire && ((kind_i == KindEncode) || (kind_i == KindFlush))) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_flush_q <= (kind_i == KindFlush);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      bit_total_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      bit_total_q <= bit_total_d;
    end
  end

  hcbp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign out_byte_o   = head.out_byte;
  assign byte_valid_o = head.byte_valid;
  assign last_o       = head.last;
  assign total_bits_o = head.total_bits;

  `ASSERT_AT(a_flush_clears, clk_i, rst_ni, (s1_fire && s1_flush_q) |=> ((pend_cnt_q == '0) && (bit_total_q == '0)))
  `ASSERT_AT(a_empty_is_last, clk_i, rst_ni, (out_valid_o && !byte_valid_o) |-> last_o)
  `ASSERT_NEVER(a_pend_clean, clk_i, rst_ni, (pend_bits_q >> pend_cnt_q) != '0)

endmodule

// ===== hdl/hcbp_out_fifo.sv =====
`include "assert_macros.svh"

module hcbp_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hcbp_pkg::hcbp_push_t  push_i,
  output logic                  room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hcbp_pkg::hcbp_result_t head_o
);
  import hcbp_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int QCntW = $clog2(Depth + 1);

  hcbp_result_t     ent_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  assign out_valid_o = (count_q != '0);
  assign head_o      = ent_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // two free slots needed before the packer may advance
  assign room_o      = (count_q <= QCntW'(Depth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + QCntW'(push_i.count) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) ent_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) ent_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, count_q > QCntW'(Depth))
  `ASSERT_AT(a_push_fits, clk_i, rst_ni, (push_i.count != 2'd0) |-> room_o)
  `ASSERT_AT(a_ptr_count, clk_i, rst_ni, (wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])

endmodule

// ===== dv/huffman_code_table_bit_packer_top_test.sv =====
module huffman_code_table_bit_packer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam logic [KindW-1:0] KindSpare = 2'd3;
  localparam int MaxLen = 16;
  localparam int ItemTarget = 650;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [KindW-1:0]      kind_i = '0;
  logic [SymW-1:0]       symbol_i = '0;
  logic [LenFieldW-1:0]  code_length_i = '0;
  logic [CodeFieldW-1:0] code_bits_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [ByteW-1:0]      out_byte_o;
  logic                  byte_valid_o;
  logic                  last_o;
  logic [TotalW-1:0]     total_bits_o;

  huffman_code_table_bit_packer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .symbol_i      (symbol_i),
    .code_length_i (code_length_i),
    .code_bits_i   (code_bits_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .total_bits_o  (total_bits_o)
  );

  // Shadow of the code table and the byte packer
  logic [LenFieldW-1:0]  code_len_tbl [256];
  logic [CodeFieldW-1:0] code_val_tbl [256];
  logic [PendW-1:0]      pack_acc;
  logic [CntW-1:0]       pack_cnt;
  logic [TotalW-1:0]     stream_bits;
  hcbp_result_t          packed_out_q [$];

  logic [SymW-1:0] pool_sym [8];

  int  fail_count;
  int  items_sent;
  int  encode_count;
  int  flush_count;
  int  stream_count;
  int  results_checked;
  int  tx_gap_next;
  bit  in_valid_held;
  bit  tx_steady;
  bit  rx_steady;
  int  rx_stall_left;
  int  rx_roll;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("huffman_code_table_bit_packer_top verification failed");
    $finish;
  end

  task automatic encode_model(input logic [KindW-1:0] kind, input logic [SymW-1:0] sym,
                              input logic [LenFieldW-1:0] len,
                              input logic [CodeFieldW-1:0] code);
    logic [LenFieldW-1:0]  n_bits;
    logic [CodeFieldW-1:0] word;
    logic [7:0]            acc;
    logic [7:0]            done_bytes [2];
    logic [32:0]           sum;
    hcbp_result_t          res;
    int                    cnt;
    int                    n_done;
    int                    i;
    case (kind)
      KindLoad: begin
        code_len_tbl[sym] = (int'(len) > MaxLen) ? LenFieldW'(MaxLen) : len;
        code_val_tbl[sym] = code;
      end
      KindEncode: begin
        n_bits = code_len_tbl[sym];
        word   = code_val_tbl[sym];
        if (n_bits != 0) begin
          acc    = {1'b0, pack_acc};
          cnt    = int'(pack_cnt);
          n_done = 0;
          // shift in the code MSB first, emit on every eighth bit
          for (i = int'(n_bits) - 1; i >= 0; i--) begin
            acc = {acc[6:0], word[i]};
            cnt++;
            if (cnt == 8) begin
              done_bytes[n_done] = acc;
              n_done++;
              acc = '0;
              cnt = 0;
            end
          end
          pack_acc    = acc[PendW-1:0];
          pack_cnt    = CntW'(cnt);
          sum         = {1'b0, stream_bits} + 33'(n_bits);
          stream_bits = sum[32] ? '1 : sum[31:0];
          for (i = 0; i < n_done; i++) begin
            res.out_byte   = done_bytes[i];
            res.byte_valid = 1'b1;
            res.last       = (i == n_done - 1);
            res.total_bits = stream_bits;
            packed_out_q.push_back(res);
          end
        end
      end
      KindFlush: begin
        acc            = {1'b0, pack_acc};
        res.out_byte   = (pack_cnt != 0) ? acc << (8 - int'(pack_cnt)) : '0;
        res.byte_valid = (pack_cnt != 0);
        res.last       = 1'b1;
        res.total_bits = stream_bits;
        packed_out_q.push_back(res);
        pack_acc    = '0;
        pack_cnt    = '0;
        stream_bits = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_packer_item(input logic [KindW-1:0] kind, input logic [SymW-1:0] sym,
                                  input logic [LenFieldW-1:0] len,
                                  input logic [CodeFieldW-1:0] code);
    int roll;
    if (tx_gap_next > 0) repeat (tx_gap_next) @(posedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    symbol_i      <= sym;
    code_length_i <= len;
    code_bits_i   <= code;
    in_valid_held = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    encode_model(kind, sym, len, code);
    if (kind != KindSpare) items_sent++;
    if (kind == KindEncode) encode_count++;
    if (kind == KindFlush) flush_count++;
    // choose the gap before the next transaction; keep valid high only when none
    roll = $urandom_range(99);
    if (tx_steady || roll < 50) tx_gap_next = 0;
    else if (roll < 92) tx_gap_next = $urandom_range(3, 1);
    else tx_gap_next = $urandom_range(30, 5);
    if (tx_gap_next > 0) begin
      in_valid_i    <= 1'b0;
      in_valid_held = 1'b0;
    end
  endtask

  task automatic wait_for_results();
    if (in_valid_held) begin
      in_valid_i    <= 1'b0;
      in_valid_held = 1'b0;
    end
    @(posedge clk_i);
    while (packed_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_packed_byte();
    hcbp_result_t want;
    if (packed_out_q.size() == 0) begin
      $error("unexpected output transaction: out_byte %0h last %0b", out_byte_o, last_o);
      fail_count++;
      return;
    end
    want = packed_out_q.pop_front();
    if (out_byte_o !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
      fail_count++;
    end
    if (byte_valid_o !== want.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid_o);
      fail_count++;
    end
    if (last_o !== want.last) begin
      $error("last: expected %0b, got %0b", want.last, last_o);
      fail_count++;
    end
    if (total_bits_o !== want.total_bits) begin
      $error("total_bits: expected %0d, got %0d", want.total_bits, total_bits_o);
      fail_count++;
    end
    results_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_packed_byte();
    if (rx_steady) begin
      out_ready_i <= 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      rx_roll = $urandom_range(99);
      if (rx_roll < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_stall_left = (rx_roll < 95) ? $urandom_range(2) : $urandom_range(40, 10);
        out_ready_i <= 1'b0;
      end
    end
  end

  // Nothing loaded yet: every symbol has length zero
  task automatic test_cleared_table();
    send_packer_item(KindEncode, 8'h00, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'hFF, 5'd31, 16'hFFFF);
    send_packer_item(KindEncode, 8'hA5, 5'd16, 16'h5A5A);
    send_packer_item(KindFlush, 8'h00, 5'd0, 16'h0000);
  endtask

  task automatic test_code_extremes();
    send_packer_item(KindLoad, 8'hFF, 5'd16, 16'hFFFF);
    send_packer_item(KindLoad, 8'h00, 5'd1, 16'h0001);
    send_packer_item(KindLoad, 8'h80, 5'd31, 16'hAAAA);
    send_packer_item(KindLoad, 8'h7F, 5'd17, 16'h5555);
    send_packer_item(KindLoad, 8'h01, 5'd0, 16'hFFFF);
    send_packer_item(KindLoad, 8'h02, 5'd8, 16'h0000);
    send_packer_item(KindEncode, 8'hFF, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'h00, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'hFF, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'h80, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'h7F, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'h01, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'h03, 5'd0, 16'h0000);
    send_packer_item(KindSpare, 8'hFF, 5'd31, 16'hFFFF);
    send_packer_item(KindEncode, 8'h02, 5'd0, 16'h0000);
    send_packer_item(KindEncode, 8'h00, 5'd0, 16'h0000);
    send_packer_item(KindFlush, 8'hFF, 5'd31, 16'hFFFF);
    send_packer_item(KindFlush, 8'h00, 5'd0, 16'h0000);
  endtask

  // Stop sending mid-stream until the output side has caught up
  task automatic test_drain_pause();
    int i;
    send_packer_item(KindLoad, 8'h10, 5'd5, 16'h0013);
    send_packer_item(KindLoad, 8'h20, 5'd11, 16'h06C9);
    for (i = 0; i < 6; i++) send_packer_item(KindEncode, (i % 2) ? 8'h10 : 8'h20, '0, '0);
    wait_for_results();
    for (i = 0; i < 4; i++) send_packer_item(KindEncode, 8'h20, '0, '0);
    send_packer_item(KindFlush, '0, '0, '0);
    wait_for_results();
  endtask

  task automatic test_random_streams();
    int i;
    int n_loads;
    int n_enc;
    int roll;
    int slot;
    logic [LenFieldW-1:0] len;
    foreach (pool_sym[i]) begin
      pool_sym[i] = SymW'($urandom_range(255));
      send_packer_item(KindLoad, pool_sym[i], LenFieldW'($urandom_range(16, 1)),
                       CodeFieldW'($urandom_range(65535)));
    end
    while (items_sent < ItemTarget) begin
      tx_steady = ($urandom_range(4) == 0);
      rx_steady = ($urandom_range(4) == 0);
      n_loads = $urandom_range(6);
      for (i = 0; i < n_loads; i++) begin
        slot = $urandom_range(7);
        roll = $urandom_range(19);
        if (roll == 0) len = '0;
        else if (roll == 1) len = LenFieldW'($urandom_range(31, 17));
        else len = LenFieldW'($urandom_range(16, 1));
        // occasionally retarget a pool slot to a fresh symbol
        if (roll == 2) pool_sym[slot] = SymW'($urandom_range(255));
        send_packer_item(KindLoad, pool_sym[slot], len, CodeFieldW'($urandom_range(65535)));
      end
      n_enc = $urandom_range(30, 4);
      for (i = 0; i < n_enc; i++) begin
        roll = $urandom_range(19);
        if (roll == 0)
          send_packer_item(KindSpare, SymW'($urandom_range(255)),
                           LenFieldW'($urandom_range(31)),
                           CodeFieldW'($urandom_range(65535)));
        else if (roll == 1)
          send_packer_item(KindEncode, SymW'($urandom_range(255)),
                           LenFieldW'($urandom_range(31)),
                           CodeFieldW'($urandom_range(65535)));
        else
          send_packer_item(KindEncode, pool_sym[$urandom_range(7)],
                           LenFieldW'($urandom_range(31)),
                           CodeFieldW'($urandom_range(65535)));
      end
      if ($urandom_range(9) != 0)
        send_packer_item(KindFlush, SymW'($urandom_range(255)),
                         LenFieldW'($urandom_range(31)),
                         CodeFieldW'($urandom_range(65535)));
      stream_count++;
      if (stream_count % 5 == 0) wait_for_results();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    foreach (code_len_tbl[i]) begin
      code_len_tbl[i] = '0;
      code_val_tbl[i] = '0;
    end
    pack_acc    = '0;
    pack_cnt    = '0;
    stream_bits = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_table();
    test_code_extremes();
    test_drain_pause();
    test_random_streams();

    wait_for_results();
    repeat (10) @(posedge clk_i);
    $display("covered %0d items over %0d random streams: %0d encodes, %0d flushes",
             items_sent, stream_count, encode_count, flush_count);
    $display("compared %0d output transactions field by field", results_checked);
    if (fail_count == 0) begin
      $display("huffman_code_table_bit_packer_top verification clean");
    end else begin
      $display("huffman_code_table_bit_packer_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/hcbp_pkg.sv
hdl/hcbp_out_fifo.sv
hdl/huffman_code_table_bit_packer_top.sv
dv/huffman_code_table_bit_packer_top_test.sv
